FILE: design/erft_pkg.sv
// Shared widths, codes, CORDIC angle table and sideband type for the frame transform.
`default_nettype none

package erft_pkg;

  localparam int COMP_W        = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int TIME_W        = 48;
  localparam int TIME_LO_W     = 32;
  localparam int TIME_HI_W     = TIME_W - TIME_LO_W;
  localparam int RATE_W        = 32;
  localparam int ANG_W         = 32;
  localparam int CORD_W        = 32;
  localparam int FRAC_W        = 30;
  localparam int PROD_W        = CORD_W + COMP_W;
  localparam int SUM_W         = PROD_W + 1;

  localparam logic [RATE_W-1:0]        RATE_RESET = 32'd3266731485;
  localparam logic signed [CORD_W-1:0] GAIN_Q30   = 32'sd652032874;

  // One eighth of a turn in Q0.32 turns
  localparam logic [ANG_W-1:0] EIGHTH_TURN = ANG_W'(1) << (ANG_W - 3);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic FUNC_TO_FIXED    = 1'b0;
  localparam logic FUNC_TO_INERTIAL = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [1:0]               quad;
    logic signed [COMP_W-1:0] vx;
    logic signed [COMP_W-1:0] vy;
    logic signed [COMP_W-1:0] vz;
  } erft_side_t;

  // atan(2^-k) in Q0.32 turns
  function automatic logic signed [ANG_W-1:0] atan_turns(input int unsigned k);
    logic signed [ANG_W-1:0] a;
    case (k)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      24:      a = 32'h00000029;
      25:      a = 32'h00000014;
      26:      a = 32'h0000000A;
      27:      a = 32'h00000005;
      28:      a = 32'h00000003;
      29:      a = 32'h00000001;
      30:      a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/erft_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage.
`default_nettype none

module erft_cordic import erft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [ANG_W-1:0]  z_i,
  input  erft_side_t               side_i,
  output logic                     valid_o,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output erft_side_t               side_o
);

  logic                     v_w    [CORDIC_STAGES];
  logic signed [CORD_W-1:0] x_w    [CORDIC_STAGES];
  logic signed [CORD_W-1:0] y_w    [CORDIC_STAGES];
  logic signed [ANG_W-1:0]  z_w    [CORDIC_STAGES-1];
  erft_side_t               side_w [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN = atan_turns(i);

    logic                     v_in;
    logic signed [CORD_W-1:0] x_in;
    logic signed [CORD_W-1:0] y_in;
    logic signed [ANG_W-1:0]  z_in;
    erft_side_t               s_in;
    logic signed [CORD_W-1:0] x_d;
    logic signed [CORD_W-1:0] y_d;
    logic                     v_q;
    logic signed [CORD_W-1:0] x_q;
    logic signed [CORD_W-1:0] y_q;
    erft_side_t               s_q;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_w[i-1];
      assign x_in = x_w[i-1];
      assign y_in = y_w[i-1];
      assign z_in = z_w[i-1];
      assign s_in = side_w[i-1];
    end

    always_comb begin
      if (!z_in[ANG_W-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q <= x_d;
        y_q <= y_d;
        s_q <= s_in;
      end
    end

    assign v_w[i]    = v_q;
    assign x_w[i]    = x_q;
    assign y_w[i]    = y_q;
    assign side_w[i] = s_q;

    // The last stage has no use for the residual angle
    if (i < CORDIC_STAGES - 1) begin : g_angle
      logic signed [ANG_W-1:0] z_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q <= z_in[ANG_W-1] ? (z_in + ATAN) : (z_in - ATAN);
        end
      end

      assign z_w[i] = z_q;
    end
  end

  assign valid_o = v_w[CORDIC_STAGES-1];
  assign x_o     = x_w[CORDIC_STAGES-1];
  assign y_o     = y_w[CORDIC_STAGES-1];
  assign side_o  = side_w[CORDIC_STAGES-1];

endmodule

`default_nettype wire

FILE: design/earth_rotation_frame_transform.sv
// Top level: z-axis rotation between the inertial and Earth-fixed frames.
//
// Input channel: in_valid_i with func, time (Q32.16 s) and a vector; a transfer
// happens on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with the rotated vector; a transfer happens on
// a clock edge with out_valid_o high and out_stall_i low.
// rotation_rate_we_i writes the rate (Q0.48 turns/s); write it only while idle.
// Pipeline steps: angle multiply, phase reduction, one CORDIC micro-rotation per
// stage, vector multiply, sum, and the output register. Throughput is one item
// per cycle while in_stall_o is low; the pipeline is fully registered and every
// stage advances together.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; only then does in_stall_o rise, freezing the
// pipeline without losing or repeating anything.
// Reset clears all valid bits and loads the rate with its Earth default.
`default_nettype none

module earth_rotation_frame_transform import erft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rotation_rate_we_i,
  input  logic [RATE_W-1:0]        rotation_rate_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [TIME_W-1:0]        time_seconds_i,
  input  logic signed [COMP_W-1:0] vec_x_i,
  input  logic signed [COMP_W-1:0] vec_y_i,
  input  logic signed [COMP_W-1:0] vec_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COMP_W-1:0] out_x_o,
  output logic signed [COMP_W-1:0] out_y_o,
  output logic signed [COMP_W-1:0] out_z_o
);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [SUM_W-1:0] v);
    logic signed [COMP_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COMP_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COMP_W-1:0];
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

  logic en;

  logic [RATE_W-1:0] rotation_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_rate_q <= RATE_RESET;
    end else if (rotation_rate_we_i) begin
      rotation_rate_q <= rotation_rate_i;
    end
  end

  // Stage 1: time times rate, split into a 32x32 and a 16x32 product
  logic [TIME_LO_W+RATE_W-1:0] plo_d;
  logic [TIME_HI_W+RATE_W-1:0] phi_d;
  logic                        s1_valid_q;
  logic [TIME_LO_W+RATE_W-1:0] s1_plo_q;
  logic [ANG_W-1:0]            s1_phi_q;
  logic                        s1_func_q;
  logic signed [COMP_W-1:0]    s1_vx_q;
  logic signed [COMP_W-1:0]    s1_vy_q;
  logic signed [COMP_W-1:0]    s1_vz_q;

  assign plo_d = time_seconds_i[TIME_LO_W-1:0] * rotation_rate_q;
  assign phi_d = time_seconds_i[TIME_W-1:TIME_LO_W] * rotation_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_plo_q  <= plo_d;
      s1_phi_q  <= phi_d[ANG_W-1:0];
      s1_func_q <= func_i;
      s1_vx_q   <= vec_x_i;
      s1_vy_q   <= vec_y_i;
      s1_vz_q   <= vec_z_i;
    end
  end

  // Stage 2: phase modulo one turn, quadrant and residual angle
  logic [ANG_W-1:0]        phase_d;
  logic [ANG_W-1:0]        shifted_d;
  logic signed [ANG_W-1:0] resid_d;
  erft_side_t              side_d;
  logic                    s2_valid_q;
  logic signed [ANG_W-1:0] s2_z_q;
  erft_side_t              s2_side_q;

  assign phase_d   = s1_phi_q + s1_plo_q[TIME_LO_W+RATE_W-1 -: ANG_W];
  assign shifted_d = phase_d + EIGHTH_TURN;
  assign resid_d   = signed'({2'b00, shifted_d[ANG_W-3:0]} - EIGHTH_TURN);

  always_comb begin
    side_d.func = s1_func_q;
    side_d.quad = shifted_d[ANG_W-1 -: 2];
    side_d.vx   = s1_vx_q;
    side_d.vy   = s1_vy_q;
    side_d.vz   = s1_vz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_z_q    <= resid_d;
      s2_side_q <= side_d;
    end
  end

  logic                     cor_valid;
  logic signed [CORD_W-1:0] cor_x;
  logic signed [CORD_W-1:0] cor_y;
  erft_side_t               cor_side;

  erft_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid_q),
    .z_i     (s2_z_q),
    .side_i  (s2_side_q),
    .valid_o (cor_valid),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .side_o  (cor_side)
  );

  // Product stage: map quadrant to cos/sin, four multiplies
  logic signed [CORD_W-1:0] cos_d;
  logic signed [CORD_W-1:0] sin_d;
  logic                     pm_valid_q;
  logic signed [PROD_W-1:0] pm_cvx_q;
  logic signed [PROD_W-1:0] pm_svy_q;
  logic signed [PROD_W-1:0] pm_cvy_q;
  logic signed [PROD_W-1:0] pm_svx_q;
  logic                     pm_func_q;
  logic signed [COMP_W-1:0] pm_vz_q;

  always_comb begin
    case (cor_side.quad)
      QUAD_0: begin
        cos_d = cor_x;
        sin_d = cor_y;
      end
      QUAD_1: begin
        cos_d = -cor_y;
        sin_d = cor_x;
      end
      QUAD_2: begin
        cos_d = -cor_x;
        sin_d = -cor_y;
      end
      default: begin
        cos_d = cor_y;
        sin_d = -cor_x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_valid_q <= 1'b0;
    end else if (en) begin
      pm_valid_q <= cor_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_cvx_q  <= PROD_W'(cos_d) * PROD_W'(cor_side.vx);
      pm_svy_q  <= PROD_W'(sin_d) * PROD_W'(cor_side.vy);
      pm_cvy_q  <= PROD_W'(cos_d) * PROD_W'(cor_side.vy);
      pm_svx_q  <= PROD_W'(sin_d) * PROD_W'(cor_side.vx);
      pm_func_q <= cor_side.func;
      pm_vz_q   <= cor_side.vz;
    end
  end

  // Sum stage: combine products per direction, add the rounding half
  logic signed [SUM_W-1:0]  sum_x_d;
  logic signed [SUM_W-1:0]  sum_y_d;
  logic                     sa_valid_q;
  logic signed [SUM_W-1:0]  sa_x_q;
  logic signed [SUM_W-1:0]  sa_y_q;
  logic signed [COMP_W-1:0] sa_vz_q;

  always_comb begin
    if (pm_func_q == FUNC_TO_FIXED) begin
      sum_x_d = SUM_W'(pm_cvx_q) + SUM_W'(pm_svy_q) + ROUND_HALF;
      sum_y_d = SUM_W'(pm_cvy_q) - SUM_W'(pm_svx_q) + ROUND_HALF;
    end else begin
      sum_x_d = SUM_W'(pm_cvx_q) - SUM_W'(pm_svy_q) + ROUND_HALF;
      sum_y_d = SUM_W'(pm_cvy_q) + SUM_W'(pm_svx_q) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
    end else if (en) begin
      sa_valid_q <= pm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_x_q  <= sum_x_d;
      sa_y_q  <= sum_y_d;
      sa_vz_q <= pm_vz_q;
    end
  end

  // Output register plus one skid entry
  logic signed [COMP_W-1:0] tail_x;
  logic signed [COMP_W-1:0] tail_y;
  logic                     out_valid_q;
  logic signed [COMP_W-1:0] out_x_q;
  logic signed [COMP_W-1:0] out_y_q;
  logic signed [COMP_W-1:0] out_z_q;
  logic                     skid_valid_q;
  logic signed [COMP_W-1:0] skid_x_q;
  logic signed [COMP_W-1:0] skid_y_q;
  logic signed [COMP_W-1:0] skid_z_q;

  assign tail_x = sat_comp(sa_x_q >>> FRAC_W);
  assign tail_y = sat_comp(sa_y_q >>> FRAC_W);
  assign en     = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain skid once the receiver takes the output
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= sa_valid_q;
    end else if (sa_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
        out_z_q <= skid_z_q;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_x_q <= tail_x;
      out_y_q <= tail_y;
      out_z_q <= sa_vz_q;
    end else begin
      skid_x_q <= tail_x;
      skid_y_q <= tail_y;
      skid_z_q <= sa_vz_q;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

endmodule

`default_nettype wire

FILE: design/erft_checker.sv
// Port-level checker for the frame transform, bound to the top level.
`default_nettype none

module erft_checker import erft_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [COMP_W-1:0] out_x_o,
  input logic signed [COMP_W-1:0] out_y_o,
  input logic signed [COMP_W-1:0] out_z_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o))
    else $error("stalled output payload changed");

  // Input stalls only when a full output is backed up
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without a stalled output");

endmodule

bind earth_rotation_frame_transform erft_checker u_erft_checker (.*);

`default_nettype wire

FILE: tb/tb_earth_rotation_frame_transform.sv
// Self-checking testbench for the z-axis Earth rotation frame transform.
`timescale 1ns / 1ps

module tb_earth_rotation_frame_transform;
  import erft_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_WAIT       = 8;

  localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } rotated_vec_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     rotation_rate_we_i;
  logic [RATE_W-1:0]        rotation_rate_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     func_i;
  logic [TIME_W-1:0]        time_seconds_i;
  logic signed [COMP_W-1:0] vec_x_i;
  logic signed [COMP_W-1:0] vec_y_i;
  logic signed [COMP_W-1:0] vec_z_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [COMP_W-1:0] out_x_o;
  logic signed [COMP_W-1:0] out_y_o;
  logic signed [COMP_W-1:0] out_z_o;

  // Micro-rotation angles, atan(2^-k) in Q0.32 turns
  logic [31:0] atan_lut [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  rotated_vec_t      pending_results[$];
  logic [RATE_W-1:0] rate_shadow   = RATE_RESET;
  bit                in_gaps_on    = 1'b1;
  bit                out_stalls_on = 1'b1;
  int                items_sent    = 0;
  int                results_seen  = 0;
  int                rate_writes   = 0;
  int                error_count   = 0;
  int                idle_cycles   = 0;

  earth_rotation_frame_transform DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rotation_rate_we_i (rotation_rate_we_i),
    .rotation_rate_i    (rotation_rate_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .time_seconds_i     (time_seconds_i),
    .vec_x_i            (vec_x_i),
    .vec_y_i            (vec_y_i),
    .vec_z_i            (vec_z_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_x_o            (out_x_o),
    .out_y_o            (out_y_o),
    .out_z_o            (out_z_o)
  );

  always #5 clk_i = ~clk_i;

  // a*b + c*d in Q30, round half up, clamp to the component range
  function automatic logic signed [COMP_W-1:0] round_sat_q30(
    input logic signed [63:0] a, input logic signed [63:0] b,
    input logic signed [63:0] c, input logic signed [63:0] d);
    logic signed [95:0] acc;
    logic signed [95:0] term;
    acc  = a;
    acc  = acc * b;
    term = c;
    term = term * d;
    acc  = (acc + term + (96'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    if (acc > COMP_MAX) return COMP_MAX;
    if (acc < COMP_MIN) return COMP_MIN;
    return acc[COMP_W-1:0];
  endfunction

  function automatic rotated_vec_t rotate_about_z(
    input logic fn, input logic [TIME_W-1:0] tm,
    input logic signed [COMP_W-1:0] vx, input logic signed [COMP_W-1:0] vy,
    input logic signed [COMP_W-1:0] vz, input logic [RATE_W-1:0] rate);
    logic [79:0]        prod;
    logic [ANG_W-1:0]   phase;
    logic [ANG_W-1:0]   t;
    logic [1:0]         quad;
    logic signed [63:0] cx, cy, cz, dx, dy, c, s;
    rotated_vec_t       res;
    prod  = tm;
    prod  = prod * rate;
    phase = prod[63:32];
    // Center each quadrant on zero so the residual stays within an eighth turn
    t     = phase + EIGHTH_TURN;
    quad  = t[31:30];
    cz    = $signed(64'(t[29:0])) - $signed(64'(EIGHTH_TURN));
    cx    = GAIN_Q30;
    cy    = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - $signed(64'(atan_lut[i]));
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + $signed(64'(atan_lut[i]));
      end
    end
    case (quad)
      QUAD_0:  begin c = cx;  s = cy;  end
      QUAD_1:  begin c = -cy; s = cx;  end
      QUAD_2:  begin c = -cx; s = -cy; end
      default: begin c = cy;  s = -cx; end
    endcase
    if (fn == FUNC_TO_FIXED) begin
      res.x = round_sat_q30(c, vx, s, vy);
      res.y = round_sat_q30(c, vy, -s, vx);
    end else begin
      res.x = round_sat_q30(c, vx, -s, vy);
      res.y = round_sat_q30(c, vy, s, vx);
    end
    res.z = vz;
    return res;
  endfunction

  function automatic logic signed [COMP_W-1:0] random_component();
    case ($urandom_range(0, 7))
      0:       return COMP_MAX;
      1:       return COMP_MIN;
      2:       return COMP_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic send_transform(input logic fn, input logic [TIME_W-1:0] tm,
                                input logic signed [COMP_W-1:0] vx,
                                input logic signed [COMP_W-1:0] vy,
                                input logic signed [COMP_W-1:0] vz);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      // Drop valid and scribble on the payload while idle
      in_valid_i     <= 1'b0;
      func_i         <= 1'($urandom);
      time_seconds_i <= TIME_W'({$urandom, $urandom});
      vec_x_i        <= COMP_W'($urandom);
      vec_y_i        <= COMP_W'($urandom);
      vec_z_i        <= COMP_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    time_seconds_i <= tm;
    vec_x_i        <= vx;
    vec_y_i        <= vy;
    vec_z_i        <= vz;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(rotate_about_z(fn, tm, vx, vy, vz, rate_shadow));
    items_sent++;
  endtask

  task automatic send_random_transform();
    logic [TIME_W-1:0] tm;
    case ($urandom_range(0, 5))
      0:       tm = TIME_W'($urandom_range(0, 1 << 20));
      1:       tm = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 1000));
      default: tm = TIME_W'({$urandom, $urandom});
    endcase
    send_transform(1'($urandom), tm, random_component(), random_component(),
                   random_component());
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    drain_pipeline();
    rotation_rate_we_i <= 1'b1;
    rotation_rate_i    <= value;
    @(posedge clk_i);
    rotation_rate_we_i <= 1'b0;
    rate_shadow = value;
    rate_writes++;
  endtask

  // Reset rate: zero time, end of the time range (wraps many turns), extreme vectors
  task automatic test_reset_rate();
    send_transform(FUNC_TO_FIXED,    '0, 32'sd1000, -32'sd2000, 32'sd7);
    send_transform(FUNC_TO_INERTIAL, '0, COMP_MAX, COMP_MIN, COMP_MAX);
    send_transform(FUNC_TO_FIXED,    {TIME_W{1'b1}}, COMP_MAX, COMP_MAX, COMP_MIN);
    send_transform(FUNC_TO_INERTIAL, {TIME_W{1'b1}}, COMP_MIN, COMP_MIN, '0);
    send_transform(FUNC_TO_FIXED,    TIME_W'(48'd86164 << 16), 32'sd123456, 32'sd0, -32'sd1);
    send_transform(FUNC_TO_INERTIAL, TIME_W'(48'd21600 << 16), 32'sd0, 32'sd654321, 32'sd1);
    send_transform(FUNC_TO_FIXED,    48'h8000_0000_0000, '0, '0, COMP_MIN);
    send_transform(FUNC_TO_INERTIAL, 48'h0000_0001_0000, -32'sd1, -32'sd1, COMP_MAX);
  endtask

  // With a rate of 2^31 the phase is time/2, so time j*2^30 lands on j eighths
  task automatic test_eighth_turns();
    logic [TIME_W-1:0] tm;
    write_rate(32'h8000_0000);
    for (int j = 0; j < 8; j++) begin
      tm = TIME_W'(j) << 30;
      send_transform(1'(j), tm, COMP_MAX, COMP_MAX, COMP_MIN);
      send_transform(~1'(j), tm - 2, COMP_MIN, 32'sd12345, COMP_MAX);
    end
  endtask

  task automatic test_rate_sweep();
    logic [RATE_W-1:0] rates [5];
    rates = '{32'd0, 32'd1, {RATE_W{1'b1}}, RATE_RESET, RATE_W'($urandom)};
    foreach (rates[r]) begin
      write_rate(rates[r]);
      repeat (50) send_random_transform();
    end
  endtask

  // Long streams, cycling through every mix of sender gaps and receiver stalls
  task automatic test_random_streams();
    for (int blk = 0; blk < 6; blk++) begin
      write_rate(blk[0] ? RATE_W'($urandom) : RATE_W'($urandom_range(0, 1 << 16)));
      in_gaps_on    = (blk % 4) inside {0, 1};
      out_stalls_on = (blk % 4) inside {0, 2};
      repeat (200) send_random_transform();
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin : result_check
    int           hold;
    rotated_vec_t want;
    forever begin
      hold = out_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d", out_x_o, out_y_o, out_z_o);
      end else begin
        want = pending_results.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y || out_z_o !== want.z) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     results_seen, want.x, want.y, want.z, out_x_o, out_y_o, out_z_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    rotation_rate_we_i <= 1'b0;
    rotation_rate_i    <= '0;
    in_valid_i         <= 1'b0;
    func_i             <= 1'b0;
    time_seconds_i     <= '0;
    vec_x_i            <= '0;
    vec_y_i            <= '0;
    vec_z_i            <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_rate();
    test_eighth_turns();
    test_rate_sweep();
    test_random_streams();
    drain_pipeline();

    $display("Sent %0d transforms under %0d rate writes, checked %0d rotated vectors",
             items_sent, rate_writes, results_seen);
    $display("Covered both directions, all quadrants, phase wrap and saturation with gaps");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors, %0d results missing", error_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/erft_pkg.sv
design/erft_cordic.sv
design/earth_rotation_frame_transform.sv
design/erft_checker.sv
tb/tb_earth_rotation_frame_transform.sv
